// ----- rtl/pwl_pkg.sv -----
// shared types, constants and state encoding for the piecewise-linear interpolator
package pwl_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CASE_LOW    = 2'd0;
    localparam logic [1:0] CASE_HIGH   = 2'd1;
    localparam logic [1:0] CASE_INTERP = 2'd2;
    localparam logic [1:0] CASE_EQUAL  = 2'd3;

    typedef struct packed {
        logic               op;
        logic [5:0]         entry_index;
        logic signed [31:0] point;
        logic signed [31:0] sample_value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         case_taken;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_CHK0,
        ST_CHKN,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PREV_RD,
        ST_PREV_LAT,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic latch_req;
        logic rd_first;
        logic rd_last;
        logic rd_scan;
        logic rd_prev;
        logic keep_first;
        logic keep_hi;
        logic keep_lo;
        logic scan_next;
        logic div_start;
        logic div_step;
        logic mul;
        logic out_low;
        logic out_high;
        logic out_mid;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_query;
        logic le_first;
        logic ge_last;
        logic lt_scan;
        logic div_done;
        logic equal_pts;
    } t_sts;

endpackage

// ----- rtl/pwl_ctrl.sv -----
// controller state machine for the piecewise-linear interpolator
module pwl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pwl_pkg::t_sts i_sts,
    output pwl_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import pwl_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (i_start) n_state = ST_RD0;
            ST_RD0:      n_state = i_sts.is_query ? ST_CHK0 : ST_IDLE;
            ST_CHK0:     n_state = i_sts.le_first ? ST_IDLE : ST_CHKN;
            ST_CHKN:     n_state = i_sts.ge_last ? ST_IDLE : ST_SCAN_RD;
            ST_SCAN_RD:  n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: n_state = i_sts.lt_scan ? ST_PREV_RD : ST_SCAN_RD;
            ST_PREV_RD:  n_state = ST_PREV_LAT;
            ST_PREV_LAT: n_state = i_sts.equal_pts ? ST_DONE : ST_DIV;
            ST_DIV:      if (i_sts.div_done) n_state = ST_MUL;
            ST_MUL:      n_state = ST_DONE;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.latch_req = i_start;
                o_cmd.load      = 1'b0;
            end
            ST_RD0: begin
                o_cmd.load     = ~i_sts.is_query;
                o_cmd.rd_first = i_sts.is_query;
            end
            ST_CHK0: begin
                o_cmd.keep_first = 1'b1;
                o_cmd.rd_last    = 1'b1;
                o_cmd.out_low    = i_sts.le_first;
            end
            ST_CHKN: begin
                o_cmd.out_high = i_sts.ge_last;
            end
            ST_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
            end
            ST_SCAN_CHK: begin
                o_cmd.keep_hi   = 1'b1;
                o_cmd.scan_next = ~i_sts.lt_scan;
            end
            ST_PREV_RD: begin
                o_cmd.rd_prev = 1'b1;
            end
            ST_PREV_LAT: begin
                o_cmd.keep_lo   = 1'b1;
                o_cmd.div_start = 1'b1;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_DONE: begin
                o_cmd.out_mid = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/pwl_dp.sv -----
// datapath: table memories, compares, serial divider and multiplier
module pwl_dp #(
    parameter int TABLE_DEPTH = pwl_pkg::TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pwl_pkg::t_req i_req,
    input  logic [6:0]    i_count,
    input  pwl_pkg::t_cmd i_cmd,
    output pwl_pkg::t_sts o_sts,
    output pwl_pkg::t_rsp o_rsp,
    output logic          o_valid
);
    import pwl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    logic signed [31:0] r_pmem [TABLE_DEPTH];
    logic signed [31:0] r_vmem [TABLE_DEPTH];
    logic signed [31:0] r_prd, r_vrd;
    t_req               r_req;
    logic [AW-1:0]      r_last, r_scan;
    logic signed [31:0] r_p0, r_v0, r_p1, r_v1;
    logic [32:0]        r_rem;
    logic [32:0]        r_den;
    logic [16:0]        r_quo;
    logic [5:0]         r_cnt;
    logic signed [49:0] r_prod;
    t_rsp               r_rsp;
    logic               r_valid;
    logic [AW-1:0]      w_addr;
    logic [CW-1:0]      w_n;
    logic [6:0]         w_c;
    logic [32:0]        w_off;
    logic [33:0]        w_trial;
    logic signed [32:0] w_dv;
    logic [15:0]        w_ratio;
    logic signed [32:0] w_sum;

    // clamp count into 1..depth, index of last entry
    always_comb begin
        w_c = (i_count == 7'd0) ? 7'd1 : i_count;
        if ({25'd0, w_c} > TABLE_DEPTH) begin
            w_n = CW'(TABLE_DEPTH);
        end else begin
            w_n = CW'(w_c);
        end
    end

    // read address select
    always_comb begin
        w_addr = '0;
        if (i_cmd.rd_first) begin
            w_addr = '0;
        end else if (i_cmd.rd_last) begin
            w_addr = r_last;
        end else if (i_cmd.rd_scan) begin
            w_addr = r_scan;
        end else if (i_cmd.rd_prev) begin
            w_addr = r_scan - AW'(1);
        end
    end

    // table memories: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && ({26'd0, r_req.entry_index} < TABLE_DEPTH)) begin
            r_pmem[AW'(r_req.entry_index)] <= r_req.point;
            r_vmem[AW'(r_req.entry_index)] <= r_req.sample_value;
        end
        r_prd <= r_pmem[w_addr];
        r_vrd <= r_vmem[w_addr];
    end

    // request and bracket registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_req  <= i_req;
            r_last <= AW'(w_n - CW'(1));
            r_scan <= AW'(1);
        end
        if (i_cmd.keep_first) begin
            r_p0 <= r_prd;
            r_v0 <= r_vrd;
        end
        if (i_cmd.rd_last) begin
            r_v1 <= r_v0;
        end
        if (i_cmd.keep_hi) begin
            r_p1 <= r_prd;
            r_v1 <= r_vrd;
        end
        if (i_cmd.out_high) begin
            r_v1 <= r_vrd;
        end
        if (i_cmd.scan_next) begin
            r_scan <= r_scan + AW'(1);
        end
        if (i_cmd.keep_lo) begin
            r_p0 <= r_prd;
            r_v0 <= r_vrd;
        end
    end

    assign o_sts.is_query  = (r_req.op == OP_QUERY);
    assign o_sts.le_first  = (r_req.point <= r_prd);
    assign o_sts.ge_last   = (r_req.point >= r_prd);
    assign o_sts.lt_scan   = (r_req.point < r_prd);
    assign o_sts.equal_pts = (r_prd == r_p1);
    assign o_sts.div_done  = (r_cnt == 6'd0);

    // restoring divider: offset is below the span, so 16 steps give the fraction
    assign w_off   = 33'($signed({r_req.point[31], r_req.point}) - $signed({r_prd[31], r_prd}));
    assign w_trial = {r_rem, 1'b0} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= 6'd16;
        end else if (i_cmd.div_step && r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_den <= 33'($signed({r_p1[31], r_p1}) - $signed({r_prd[31], r_prd}));
            r_rem <= w_off;
            r_quo <= '0;
        end else if (i_cmd.div_step && r_cnt != 6'd0) begin
            if (!w_trial[33]) begin
                r_rem <= w_trial[32:0];
                r_quo <= {r_quo[15:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], 1'b0};
                r_quo <= {r_quo[15:0], 1'b0};
            end
        end
    end

    // saturate ratio, product of value difference and ratio
    assign w_ratio = r_quo[16] ? 16'hFFFF : r_quo[15:0];
    assign w_dv    = $signed({r_v1[31], r_v1}) - $signed({r_v0[31], r_v0});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= 50'(w_dv * $signed({1'b0, w_ratio}));
        end
    end

    assign w_sum = $signed({r_v0[31], r_v0}) + $signed({r_v1[31], r_v1});

    // result register, one strobe per query
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_low || i_cmd.out_high || i_cmd.out_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_low) begin
            r_rsp.result_value <= r_vrd;
            r_rsp.case_taken   <= CASE_LOW;
        end else if (i_cmd.out_high) begin
            r_rsp.result_value <= r_vrd;
            r_rsp.case_taken   <= CASE_HIGH;
        end else if (i_cmd.out_mid) begin
            if (r_p0 == r_p1) begin
                r_rsp.result_value <= w_sum[32:1];
                r_rsp.case_taken   <= CASE_EQUAL;
            end else begin
                r_rsp.result_value <= r_v0 + r_prod[47:16];
                r_rsp.case_taken   <= CASE_INTERP;
            end
        end
    end

    assign o_rsp   = r_rsp;
    assign o_valid = r_valid;

endmodule

// ----- rtl/piecewise_linear_table_interp.sv -----
// top level of the piecewise-linear table interpolator
// A load holds busy in RD0 alone, a query clamped low in RD0 and CHK0, one clamped high in
// RD0, CHK0 and CHKN. Other queries add a read and a check state per entry scanned from
// entry 1 up to the first point above the query, then the read of the entry below, the
// 16-step restoring divider that forms the ratio, the multiply and the output; if the
// points below and above are equal, the two are skipped and the mean of both values is given.
// The table has one write port and one registered read port, which sets the scan pace.
// start is taken when busy is low; each answer shows for one cycle with o_valid high in the
// first cycle after busy falls, and the receiver cannot stall it. sample_count may only be
// written while busy is low.
module piecewise_linear_table_interp #(
    parameter int TABLE_DEPTH = pwl_pkg::TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pwl_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic [6:0]    i_cfg_data,
    output pwl_pkg::t_rsp o_rsp,
    output logic          o_valid
);
    import pwl_pkg::*;

    logic [6:0] r_count;
    t_cmd       w_cmd;
    t_sts       w_sts;

    // sample count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 7'd1;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    pwl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    pwl_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_count (r_count),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_rsp   (o_rsp),
        .o_valid (o_valid)
    );

    // a result never appears right after a request is taken
    a_no_valid_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result strobe right after request");

    // at most one output select at a time
    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.out_low, w_cmd.out_high, w_cmd.out_mid}))
        else $error("conflicting output selects");

    // a result is shown only while idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy while result shown");

endmodule
